// ===== src/ecpr_pkg.sv =====
`timescale 1ns / 1ps
package ecpr_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PAGE_BITS   = 20;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_ACCESS = 2'd1;
  localparam logic [1:0] REQ_VICTIM = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;
  localparam logic [1:0] STAT_ABSENT = 2'd3;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_ACCESS,
    CMD_WALK_START,
    CMD_STEP,
    CMD_REMOVE
  } cmd_op_t;

  // victim class searched by the walk
  typedef enum logic [1:0] {
    MODE_CLEAN,
    MODE_DIRTY,
    MODE_ANY_CLEAN,
    MODE_HEAD
  } mode_t;

  typedef struct packed {
    logic                 valid;
    logic [PAGE_BITS-1:0] page;
    logic                 ref_b;
    logic                 mod_b;
  } entry_t;

  typedef struct packed {
    cmd_op_t              op;
    logic [PAGE_BITS-1:0] page;
    logic                 ref_b;
    logic                 mod_b;
    logic                 clr_ref;
  } cell_cmd_t;

endpackage

// ===== src/ecpr_cell.sv =====
`timescale 1ns / 1ps
module ecpr_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  ecpr_pkg::cell_cmd_t cmd_i,
  input  ecpr_pkg::mode_t    mode_i,
  input  logic               left_valid_i,
  input  logic               left_token_i,
  input  ecpr_pkg::entry_t   right_i,
  output ecpr_pkg::entry_t   entry_o,
  output logic               token_o,
  output logic               take_o,
  output logic               hit_o
);
  import ecpr_pkg::*;

  logic                 valid_r;
  logic [PAGE_BITS-1:0] page_r;
  logic                 ref_r;
  logic                 mod_r;
  logic                 token_r;
  logic                 passed_r;
  logic                 hit_r;

  logic ins_en;
  logic match;
  logic pred;

  assign ins_en = (cmd_i.op == CMD_INSERT) && !valid_r && left_valid_i;
  assign match  = valid_r && (page_r == cmd_i.page);

  always_comb begin
    unique case (mode_i)
      MODE_CLEAN:     pred = !ref_r && !mod_r;
      MODE_DIRTY:     pred = !ref_r && mod_r;
      MODE_ANY_CLEAN: pred = !mod_r;
      MODE_HEAD:      pred = 1'b1;
      default:        pred = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      ref_r    <= 1'b0;
      mod_r    <= 1'b0;
      token_r  <= 1'b0;
      passed_r <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        CMD_INSERT: begin
          if (ins_en) begin
            valid_r <= 1'b1;
            ref_r   <= cmd_i.ref_b;
            mod_r   <= cmd_i.mod_b;
          end
        end
        CMD_ACCESS: begin
          hit_r <= match;
          if (match) begin
            ref_r <= ref_r | cmd_i.ref_b;
            mod_r <= mod_r | cmd_i.mod_b;
          end
        end
        CMD_WALK_START: begin
          token_r  <= left_token_i;
          passed_r <= 1'b0;
          if (cmd_i.clr_ref) begin
            ref_r <= 1'b0;
          end
        end
        CMD_STEP: begin
          token_r <= left_token_i;
          if (token_r) begin
            passed_r <= 1'b1;
            if (mode_i == MODE_DIRTY) begin
              ref_r <= 1'b0;
            end
          end
        end
        CMD_REMOVE: begin
          token_r <= 1'b0;
          if (!passed_r) begin
            valid_r <= right_i.valid;
            ref_r   <= right_i.ref_b;
            mod_r   <= right_i.mod_b;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ins_en) begin
      page_r <= cmd_i.page;
    end else if (cmd_i.op == CMD_REMOVE && !passed_r) begin
      page_r <= right_i.page;
    end
  end

  assign entry_o.valid = valid_r;
  assign entry_o.page  = page_r;
  assign entry_o.ref_b = ref_r;
  assign entry_o.mod_b = mod_r;
  assign token_o       = token_r;
  assign take_o        = token_r && valid_r && pred;
  assign hit_o         = hit_r;

endmodule

// ===== src/enhanced_clock_page_replacement.sv =====
// Flow: a start accepted in idle registers the request; insert, empty victim
// and ignored requests report from the operation state, access via a hit state,
// and a victim search walks a token along the cell row one cell per cycle.
// Throughput: one word at a time; busy stays high until the result is issued.
// The receiver cannot stall; out_valid is a one-cycle strobe.
// Reset (rst_n low, synchronous) empties the queue and clears all ref/mod bits.
`timescale 1ns / 1ps
module enhanced_clock_page_replacement (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_req_type,
  input  logic [ecpr_pkg::PAGE_BITS-1:0] in_page_number,
  input  logic                           in_referenced,
  input  logic                           in_modified,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [ecpr_pkg::PAGE_BITS-1:0] out_victim_page,
  output logic                           out_victim_dirty
);
  import ecpr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_OP   = 2'd1;
  localparam logic [1:0] S_HIT  = 2'd2;
  localparam logic [1:0] S_WALK = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [1:0]           req_r;
  logic [PAGE_BITS-1:0] page_r;
  logic                 ref_r;
  logic                 mod_r;
  mode_t                mode_r, mode_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [PAGE_BITS-1:0] out_page_r, out_page_nxt;
  logic                 out_dirty_r, out_dirty_nxt;

  cell_cmd_t            cmd;
  entry_t               ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid_v, token_v, take_v, hit_v, c1_v, c2_v, c3_v;
  logic [PAGE_BITS-1:0] sel_page;
  logic                 sel_dirty;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic   lv;
      logic   lt;
      entry_t rn;
      if (g == 0) begin : g_head
        assign lv = 1'b1;
        assign lt = (cmd.op == CMD_WALK_START);
      end else begin : g_body
        assign lv = valid_v[g-1];
        assign lt = token_v[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign rn = '0;
      end else begin : g_mid
        assign rn = ent[g+1];
      end

      ecpr_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_i        (cmd),
        .mode_i       (mode_r),
        .left_valid_i (lv),
        .left_token_i (lt),
        .right_i      (rn),
        .entry_o      (ent[g]),
        .token_o      (token_v[g]),
        .take_o       (take_v[g]),
        .hit_o        (hit_v[g])
      );

      assign valid_v[g] = ent[g].valid;
      assign c1_v[g]    = ent[g].valid && !ent[g].ref_b && !ent[g].mod_b;
      assign c2_v[g]    = ent[g].valid && !ent[g].ref_b && ent[g].mod_b;
      assign c3_v[g]    = ent[g].valid && !ent[g].mod_b;
    end
  endgenerate

  always_comb begin
    sel_page  = '0;
    sel_dirty = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      sel_page  = sel_page | (ent[i].page & {PAGE_BITS{take_v[i]}});
      sel_dirty = sel_dirty | (ent[i].mod_b & take_v[i]);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    cmd.op         = CMD_NONE;
    cmd.page       = page_r;
    cmd.ref_b      = ref_r;
    cmd.mod_b      = mod_r;
    cmd.clr_ref    = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = STAT_OK;
    out_page_nxt   = '0;
    out_dirty_nxt  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_OP;
        end
      end
      S_OP: begin
        unique case (req_r)
          REQ_INSERT: begin
            cmd.op        = CMD_INSERT;
            out_valid_nxt = 1'b1;
            out_status_nxt = valid_v[QUEUE_DEPTH-1] ? STAT_FULL : STAT_OK;
            state_nxt     = S_IDLE;
          end
          REQ_ACCESS: begin
            cmd.op    = CMD_ACCESS;
            state_nxt = S_HIT;
          end
          REQ_VICTIM: begin
            if (!valid_v[0]) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_EMPTY;
              state_nxt      = S_IDLE;
            end else begin
              priority if (|c1_v) begin
                mode_nxt = MODE_CLEAN;
              end else if (|c2_v) begin
                mode_nxt = MODE_DIRTY;
              end else if (|c3_v) begin
                mode_nxt = MODE_ANY_CLEAN;
              end else begin
                mode_nxt = MODE_HEAD;
              end
              cmd.op      = CMD_WALK_START;
              cmd.clr_ref = !(|c1_v) && !(|c2_v);
              state_nxt   = S_WALK;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end
      S_HIT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = (|hit_v) ? STAT_OK : STAT_ABSENT;
        state_nxt      = S_IDLE;
      end
      S_WALK: begin
        if (|take_v) begin
          cmd.op        = CMD_REMOVE;
          out_valid_nxt = 1'b1;
          out_page_nxt  = sel_page;
          out_dirty_nxt = sel_dirty;
          state_nxt     = S_IDLE;
        end else begin
          cmd.op = CMD_STEP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_HEAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      req_r  <= in_req_type;
      page_r <= in_page_number;
      ref_r  <= in_referenced;
      mod_r  <= in_modified;
    end
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_dirty_r  <= out_dirty_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_victim_page  = out_page_r;
  assign out_victim_dirty = out_dirty_r;

  a_walk_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> $onehot(token_v))
    else $error("walk token not one-hot");

  a_token_in_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> ((token_v & ~valid_v) == '0))
    else $error("walk token beyond queue tail");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_v & (valid_v + 1'b1)) == '0))
    else $error("queue entries not contiguous from head");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) != S_IDLE))
    else $error("result word without a request in progress");

endmodule
